// ----- rtl/core/lvdd_pkg.sv -----
`default_nettype none

package lvdd_pkg;

  // widths of the value and of its decimal form
  localparam int unsigned ValueW  = 32;
  localparam int unsigned Digits  = 10;
  localparam int unsigned BcdW    = 4 * Digits;
  localparam int unsigned NdigW   = 4;
  localparam int unsigned IndexW  = 3;

  // one converted window entry
  typedef struct packed {
    logic             neg;
    logic [NdigW-1:0] ndig;
    logic [BcdW-1:0]  bcd;
  } entry_t;

endpackage

`default_nettype wire

// ----- rtl/core/lvdd_front.sv -----
`default_nettype none

module lvdd_front import lvdd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [ValueW-1:0] in_value_i,
  output logic                   push_valid_o,
  input  wire logic              push_ready_i,
  output entry_t                 push_data_o
);

  localparam int unsigned BitsPerStep = 4;
  localparam int unsigned Steps       = ValueW / BitsPerStep;
  localparam int unsigned StepW       = $clog2(Steps);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [StepW-1:0]  step_q, step_d;
  logic              neg_q, neg_d;
  logic [ValueW-1:0] mag_q, mag_d;
  logic [BcdW-1:0]   bcd_q, bcd_d;
  logic              accept, push;
  logic [ValueW-1:0] mag_next;
  logic [BcdW-1:0]   bcd_next;
  logic [NdigW-1:0]  ndig;

  // one shift-and-add-three step of the double dabble
  function automatic logic [BcdW-1:0] dd_step(input logic [BcdW-1:0] b, input logic bit_in);
    logic [BcdW-1:0] r;
    r = b;
    for (int d = 0; d < Digits; d++) begin
      if (r[4*d +: 4] >= 4'd5) begin
        r[4*d +: 4] = r[4*d +: 4] + 4'd3;
      end
    end
    return {r[BcdW-2:0], bit_in};
  endfunction

  // four magnitude bits per cycle
  always_comb begin
    logic [ValueW-1:0] m;
    logic [BcdW-1:0]   b;
    m = mag_q;
    b = bcd_q;
    for (int j = 0; j < BitsPerStep; j++) begin
      b = dd_step(b, m[ValueW-1]);
      m = {m[ValueW-2:0], 1'b0};
    end
    mag_next = m;
    bcd_next = b;
  end

  // digit count from the highest non-zero nibble, zero shows as one digit
  always_comb begin
    ndig = NdigW'(1);
    for (int d = 0; d < Digits; d++) begin
      if (bcd_q[4*d +: 4] != 4'd0) begin
        ndig = NdigW'(d + 1);
      end
    end
  end

  assign push         = done_q && push_ready_i;
  assign in_ready_o   = !busy_q || push;
  assign accept       = in_valid_i && in_ready_o;
  assign push_valid_o = done_q;
  assign push_data_o  = '{neg: neg_q, ndig: ndig, bcd: bcd_q};

  // control and datapath next state
  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    step_d = step_q;
    neg_d  = neg_q;
    mag_d  = mag_q;
    bcd_d  = bcd_q;
    if (push) begin
      busy_d = 1'b0;
      done_d = 1'b0;
    end
    if (accept) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      step_d = '0;
      neg_d  = in_value_i[ValueW-1];
      mag_d  = in_value_i[ValueW-1] ? (~in_value_i + 1'b1) : in_value_i;
      bcd_d  = '0;
    end else if (busy_q && !done_q) begin
      mag_d  = mag_next;
      bcd_d  = bcd_next;
      step_d = step_q + 1'b1;
      if (step_q == StepW'(Steps - 1)) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    mag_q <= mag_d;
    bcd_q <= bcd_d;
  end

  // a finished conversion always belongs to a busy front
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> busy_q)
    else $error("front done without busy");
  // an accepted item restarts the step count
  a_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (step_q == '0) && !done_q)
    else $error("front did not restart");
  // done rises only after the last step
  a_done_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> (step_q == '0))
    else $error("front done early");

endmodule

`default_nettype wire

// ----- rtl/core/lvdd_fifo.sv -----
`default_nettype none

module lvdd_fifo import lvdd_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   wr_valid_i,
  output logic        wr_ready_o,
  input  entry_t      wr_data_i,
  output logic        rd_valid_o,
  input  wire logic   rd_ready_i,
  output entry_t      rd_data_o
);

  entry_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       wr, rd;

  assign wr_ready_o = (count_q != 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign wr         = wr_valid_i && wr_ready_o;
  assign rd         = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (wr) wr_ptr_q <= !wr_ptr_q;
      if (rd) rd_ptr_q <= !rd_ptr_q;
      if (wr && !rd) begin
        count_q <= count_q + 2'd1;
      end else if (rd && !wr) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

  // pointers differ exactly when one item is held
  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd1) == (wr_ptr_q != rd_ptr_q))
    else $error("queue pointers out of step");
  // level never goes past two
  a_level: assert property (@(posedge clk_i) disable iff (!rst_ni) count_q != 2'd3)
    else $error("queue level overflow");
  // a write into an empty queue shows up next cycle
  a_wr_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr && count_q == 2'd0) |=> rd_valid_o)
    else $error("queue lost an item");

endmodule

`default_nettype wire

// ----- rtl/core/lvdd_back.sv -----
`default_nettype none

module lvdd_back import lvdd_pkg::*; #(
  parameter int unsigned WINDOW_SIZE = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_valid_i,
  output logic                   q_ready_o,
  input  entry_t                 q_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output entry_t                 out_data_o,
  output logic [IndexW-1:0]      out_index_o,
  output logic                   out_last_o
);

  localparam int unsigned FW = $clog2(WINDOW_SIZE + 1);
  localparam int unsigned CW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int unsigned SW = FW + 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic              state_q;
  logic [FW-1:0]     fill_q;
  logic [CW-1:0]     cnt_q;
  logic [IndexW-1:0] idx_q;
  entry_t            slot_q [WINDOW_SIZE];
  entry_t            slot_d [WINDOW_SIZE];
  logic              pop, rotate, shift, slot_ok, cnt_last;

  // slot at rotation step k is held when k + fill reaches the window size
  assign slot_ok  = (SW'(cnt_q) + SW'(fill_q)) >= SW'(WINDOW_SIZE);
  assign cnt_last = (cnt_q == CW'(WINDOW_SIZE - 1));
  assign pop      = (state_q == ST_IDLE) && q_valid_i;
  assign rotate   = (state_q == ST_EMIT) && (!slot_ok || out_ready_i);
  assign shift    = pop || rotate;

  assign q_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT) && slot_ok;
  assign out_data_o  = slot_q[0];
  assign out_index_o = idx_q;
  assign out_last_o  = cnt_last;

  // window loop: a pop shifts the new entry in at the top, a rotate wraps slot 0
  for (genvar i = 0; i < WINDOW_SIZE; i++) begin : g_slot
    if (i == WINDOW_SIZE - 1) begin : g_top
      assign slot_d[i] = pop ? q_data_i : slot_q[0];
    end else begin : g_mid
      assign slot_d[i] = slot_q[i+1];
    end
    always_ff @(posedge clk_i) begin
      if (shift) slot_q[i] <= slot_d[i];
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (pop) begin
            state_q <= ST_EMIT;
            cnt_q   <= '0;
            idx_q   <= '0;
            if (fill_q != FW'(WINDOW_SIZE)) begin
              fill_q <= fill_q + 1'b1;
            end
          end
        end
        ST_EMIT: begin
          if (out_valid_o && out_ready_i) begin
            idx_q <= idx_q + 1'b1;
          end
          if (rotate) begin
            if (cnt_last) begin
              state_q <= ST_IDLE;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // fill level stays within the window
  a_fill_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(WINDOW_SIZE))
    else $error("fill level beyond window");
  // a pop starts a full rotation from step zero
  a_pop_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (state_q == ST_EMIT) && (cnt_q == '0) && (fill_q != '0))
    else $error("emission did not start");
  // the newest entry is always a held one
  a_last_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && cnt_last) |-> slot_ok)
    else $error("newest entry not held");

endmodule

`default_nettype wire

// ----- rtl/core/last_values_decimal_dump_top.sv -----
`default_nettype none

// channel   direction  handshake                        payload
// value     in         value_valid_i / value_ready_o    value_i
// result    out        result_valid_o / result_ready_i  entry_index_o, is_negative_o,
//                                                       digit_count_o, bcd_digits_o, is_last_o
//
// the front converts each value to BCD, 4 bits a cycle of double dabble,
// and can take the next value in the cycle its result enters the 2-entry queue
// the back shifts the entry into the window and rotates it once, one result per held entry,
// and pops the next entry only after the rotation; conversion overlaps emission
// result stalls hold the rotation; the queue lets the front keep converting meanwhile
// reset clears the window fill level and all control state, no clearing pass

module last_values_decimal_dump_top import lvdd_pkg::*; #(
  parameter int unsigned WINDOW_SIZE = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              value_valid_i,
  output logic                   value_ready_o,
  input  wire logic [ValueW-1:0] value_i,
  output logic                   result_valid_o,
  input  wire logic              result_ready_i,
  output logic [IndexW-1:0]      entry_index_o,
  output logic                   is_negative_o,
  output logic [NdigW-1:0]       digit_count_o,
  output logic [BcdW-1:0]        bcd_digits_o,
  output logic                   is_last_o
);

  logic   push_valid, push_ready, pop_valid, pop_ready;
  entry_t push_data, pop_data, out_data;

  // conversion front
  lvdd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (value_valid_i),
    .in_ready_o   (value_ready_o),
    .in_value_i   (value_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // queue between front and back
  lvdd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_data_i  (push_data),
    .rd_valid_o (pop_valid),
    .rd_ready_i (pop_ready),
    .rd_data_o  (pop_data)
  );

  // window and emission back
  lvdd_back #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (pop_valid),
    .q_ready_o   (pop_ready),
    .q_data_i    (pop_data),
    .out_valid_o (result_valid_o),
    .out_ready_i (result_ready_i),
    .out_data_o  (out_data),
    .out_index_o (entry_index_o),
    .out_last_o  (is_last_o)
  );

  assign is_negative_o = out_data.neg;
  assign digit_count_o = out_data.ndig;
  assign bcd_digits_o  = out_data.bcd;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lvdd_pkg::*;

  localparam int unsigned WindowSize = 8;
  localparam int unsigned NumRandom  = 220;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DrainWait  = 40;

  // one converted window entry as it leaves the block
  typedef struct {
    logic [IndexW-1:0] idx;
    entry_t            conv;
    logic              last;
  } dump_entry_t;

  // window predictor and store of expected entries
  class window_board;
    logic [ValueW-1:0] window_vals[WindowSize];
    int unsigned       held;
    dump_entry_t       pending_entries[$];
    int unsigned       errors;

    function new();
      foreach (window_vals[i]) window_vals[i] = '0;
      held   = 0;
      errors = 0;
    endfunction

    // decimal digits of a magnitude, low digit in the low nibble
    function void to_bcd(input logic [ValueW-1:0] mag, output logic [BcdW-1:0] bcd,
                         output logic [NdigW-1:0] nd);
      logic [ValueW-1:0] rest;
      int                cnt;
      bcd  = '0;
      cnt  = 0;
      rest = mag;
      do begin
        bcd[4*cnt +: 4] = 4'(rest % 10);
        rest = rest / 10;
        cnt++;
      end while (rest != 0 && cnt < Digits);
      nd = NdigW'(cnt);
    endfunction

    // slide the new value in, then expect the whole window oldest first
    function void note_value(logic [ValueW-1:0] v);
      dump_entry_t       e;
      logic [ValueW-1:0] w;
      logic [ValueW-1:0] mag;
      if (held < WindowSize) begin
        window_vals[held] = v;
        held++;
      end else begin
        for (int i = 1; i < WindowSize; i++) window_vals[i-1] = window_vals[i];
        window_vals[WindowSize-1] = v;
      end
      for (int unsigned i = 0; i < held; i++) begin
        w           = window_vals[i];
        e.idx       = IndexW'(i);
        e.conv.neg  = w[ValueW-1];
        mag         = e.conv.neg ? (ValueW'(0) - w) : w;
        to_bcd(mag, e.conv.bcd, e.conv.ndig);
        e.last      = (i + 1 == held);
        pending_entries.push_back(e);
      end
    endfunction

    function void check_entry(dump_entry_t got);
      dump_entry_t exp_e;
      if (pending_entries.size() == 0) begin
        $error("unexpected result item, entry_index %0d", got.idx);
        errors++;
        return;
      end
      exp_e = pending_entries.pop_front();
      if (got.idx !== exp_e.idx) begin
        $error("entry_index expected %0d actual %0d", exp_e.idx, got.idx);
        errors++;
      end
      if (got.conv.neg !== exp_e.conv.neg) begin
        $error("is_negative expected %0b actual %0b", exp_e.conv.neg, got.conv.neg);
        errors++;
      end
      if (got.conv.ndig !== exp_e.conv.ndig) begin
        $error("digit_count expected %0d actual %0d", exp_e.conv.ndig, got.conv.ndig);
        errors++;
      end
      if (got.conv.bcd !== exp_e.conv.bcd) begin
        $error("bcd_digits expected %h actual %h", exp_e.conv.bcd, got.conv.bcd);
        errors++;
      end
      if (got.last !== exp_e.last) begin
        $error("is_last expected %0b actual %0b", exp_e.last, got.last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return pending_entries.size();
    endfunction
  endclass

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              value_valid_i  = 1'b0;
  logic [ValueW-1:0] value_i        = '0;
  logic              result_ready_i = 1'b0;
  logic              value_ready_o;
  logic              result_valid_o;
  logic [IndexW-1:0] entry_index_o;
  logic              is_negative_o;
  logic [NdigW-1:0]  digit_count_o;
  logic [BcdW-1:0]   bcd_digits_o;
  logic              is_last_o;

  window_board board = new();
  bit          steady;
  bit          hold_off_req;

  last_values_decimal_dump_top #(
    .WINDOW_SIZE(WindowSize)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_valid_i (value_valid_i),
    .value_ready_o (value_ready_o),
    .value_i       (value_i),
    .result_valid_o(result_valid_o),
    .result_ready_i(result_ready_i),
    .entry_index_o (entry_index_o),
    .is_negative_o (is_negative_o),
    .digit_count_o (digit_count_o),
    .bcd_digits_o  (bcd_digits_o),
    .is_last_o     (is_last_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // note each accepted input item
  always @(posedge clk_i) begin
    if (rst_ni && value_valid_i && value_ready_o) board.note_value(value_i);
  end

  // check each accepted result item
  always @(posedge clk_i) begin
    dump_entry_t got;
    if (rst_ni && result_valid_o && result_ready_i) begin
      got.idx       = entry_index_o;
      got.conv.neg  = is_negative_o;
      got.conv.ndig = digit_count_o;
      got.conv.bcd  = bcd_digits_o;
      got.last      = is_last_o;
      board.check_entry(got);
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (steady || r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned stall_len();
    if ($urandom_range(0, 7) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 4);
  endfunction

  // random value biased towards digit boundaries and extremes
  function automatic logic [ValueW-1:0] pick_value();
    logic [ValueW-1:0] p;
    p = 1;
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2:    return $urandom_range(0, 999);
      3:    return ValueW'(0) - $urandom_range(0, 999);
      4: begin
        repeat ($urandom_range(0, 9)) p = p * 10;
        p = p + $urandom_range(0, 2) - 1;
        return $urandom_range(0, 1) ? (ValueW'(0) - p) : p;
      end
      default: begin
        case ($urandom_range(0, 3))
          0:       return 32'h7fff_ffff;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
    endcase
  endfunction

  // offer one item and hold it until accepted
  task automatic send_value(logic [ValueW-1:0] v);
    int unsigned gap;
    gap = gap_len();
    if (gap > 0) begin
      value_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    value_valid_i <= 1'b1;
    value_i       <= v;
    do @(posedge clk_i); while (!value_ready_o);
  endtask

  // result side back-pressure
  initial begin
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        result_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (!steady && $urandom_range(0, 2) == 0) begin
        result_ready_i <= 1'b0;
        repeat (stall_len()) @(posedge clk_i);
      end
      result_ready_i <= 1'b1;
      repeat (steady ? 16 : $urandom_range(1, 10)) @(posedge clk_i);
    end
  end

  // stimulus and end of run
  initial begin
    logic [ValueW-1:0] directed[$];
    directed = '{32'd0, 32'd1, 32'hffff_ffff, 32'd9, 32'd10, 32'd99, 32'd100,
                 32'h7fff_ffff, 32'h8000_0000, 32'd999_999_999, 32'd1_000_000_000,
                 -32'sd1_000_000_000, 32'h5555_5555, 32'haaaa_aaaa, 32'd4_294_967,
                 -32'sd10, 32'h8000_0001, 32'd0};
    steady       = 1'b0;
    hold_off_req = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, digit boundaries, window fill and slide
    foreach (directed[i]) send_value(directed[i]);

    // random part, with one long receiver hold-off and one stretch without idling
    for (int i = 0; i < NumRandom; i++) begin
      if (i == 40) hold_off_req = 1'b1;
      steady = (i >= 120 && i < 160);
      send_value(pick_value());
    end
    steady = 1'b0;
    value_valid_i <= 1'b0;

    // drain
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("last_values_decimal_dump_top: match");
    end else begin
      $display("last_values_decimal_dump_top: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("last_values_decimal_dump_top: mismatch");
    $finish;
  end

endmodule

`default_nettype wire

// ----- last_values_decimal_dump_top.f -----
rtl/core/lvdd_pkg.sv
rtl/core/lvdd_front.sv
rtl/core/lvdd_fifo.sv
rtl/core/lvdd_back.sv
rtl/core/last_values_decimal_dump_top.sv
tb/testbench.sv
